FILE: design/rsu_pkg.sv
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types, constants and helpers of the per-source rate shaper.
// ----------------------------------------------------------------------------
package rsu_pkg;

	localparam int NUM_SOURCES_DEF = 8;

	localparam logic [29:0] RATE_SCALE = 30'd1000000000;

	// floor(2^61 / 1e9), reciprocal of the ewma scale
	localparam logic [31:0] RECIP_SCALE = 32'd2305843009;

	localparam logic [63:0] SCALE_X1 = 64'd1000000000;
	localparam logic [63:0] SCALE_X2 = 64'd2000000000;
	localparam logic [63:0] SCALE_X3 = 64'd3000000000;
	localparam logic [63:0] SCALE_X4 = 64'd4000000000;

	localparam logic [31:0] MIN_WINDOW_RST = 32'd10000000;
	localparam logic [39:0] WINDOW_RST     = 40'd8000000000;
	localparam logic [29:0] WEIGHT_RST     = 30'd8000;
	localparam logic [9:0]  QLIMIT_RST     = 10'd300;
	localparam logic [15:0] MIN_AVG_RST    = 16'd10;

	localparam logic [2:0] REG_MIN_WINDOW = 3'd0;
	localparam logic [2:0] REG_WINDOW     = 3'd1;
	localparam logic [2:0] REG_WEIGHT     = 3'd2;
	localparam logic [2:0] REG_QLIMIT     = 3'd3;
	localparam logic [2:0] REG_MIN_AVG    = 3'd4;

	localparam logic [6:0] DIV_STEPS = 7'd64;

	typedef struct packed {
		logic capture;
		logic load;
		logic mul;
		logic ewma_sum;
		logic ewma_recip;
		logic ewma_back;
		logic ewma_take;
		logic rate_mul;
		logic rate_start;
		logic finish;
	} rsu_cmd_t;

	typedef struct packed {
		logic src_ok;
		logic win_hit;
		logic div_done;
		logic out_free;
	} rsu_sts_t;

	function automatic logic [31:0] floor_avg(input logic [31:0] a, input logic [15:0] m);
		floor_avg = (a < {16'd0, m}) ? {16'd0, m} : a;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] a);
		sat_inc = (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

endpackage

FILE: design/per_source_rate_shaper_unit.sv
// ----------------------------------------------------------------------------
// per_source_rate_shaper_unit
// Per-source arrival averaging, service rate and virtual queue shaping.
//
// Input channel (in_valid/in_ready) carries one packet event: source index
// and nanosecond timestamp. Output channel (out_valid/out_ready) returns one
// result per event: pass flag, shaped rate, queue level and packet count.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the unit is idle, which the unit does not check.
// One event at a time. When the averaging window has elapsed, four extra
// steps for the reciprocal EWMA update run before the 64-step rate divide
// of the restoring divider; a source outside the table goes from load
// straight to finish. The next event is taken the cycle after a result is
// loaded, also while that result still waits for out_ready; a stalled
// receiver holds the sequencer only at its final step.
// Reset clears all per-source state and loads the default registers.
// ----------------------------------------------------------------------------
module per_source_rate_shaper_unit import rsu_pkg::*; #(
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  source,
	input  logic [63:0] timestamp_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pass,
	output logic [63:0] shaped_rate,
	output logic [9:0]  queue_level,
	output logic [31:0] packet_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	rsu_cmd_t cmd;
	rsu_sts_t sts;

	assign cfg_ready = 1'b1;

	rsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsu_datapath #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.source       (source),
		.timestamp_ns (timestamp_ns),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pass         (pass),
		.shaped_rate  (shaped_rate),
		.queue_level  (queue_level),
		.packet_count (packet_count)
	);

endmodule

FILE: design/rsu_div.sv
// ----------------------------------------------------------------------------
// rsu_div
// Restoring divider, one quotient bit per cycle, 64 steps.
// ----------------------------------------------------------------------------
module rsu_div import rsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] dq_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] diff;
	logic        take;

	assign trial = {rem_q, dq_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = ~diff[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[63:0] : trial[63:0];
			dq_q  <= {dq_q[62:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

FILE: design/rsu_datapath.sv
// ----------------------------------------------------------------------------
// rsu_datapath
// Per-source state, configuration registers, multipliers and result register.
// ----------------------------------------------------------------------------
module rsu_datapath import rsu_pkg::*; #(
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rsu_cmd_t    cmd,
	output rsu_sts_t    sts,
	input  logic [2:0]  source,
	input  logic [63:0] timestamp_ns,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        pass,
	output logic [63:0] shaped_rate,
	output logic [9:0]  queue_level,
	output logic [31:0] packet_count
);

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam logic [8:0] NS = 9'(NUM_SOURCES);

	logic [31:0] min_window_q;
	logic [39:0] window_q;
	logic [29:0] weight_q;
	logic [9:0]  qlimit_q;
	logic [15:0] min_avg_q;

	logic [63:0] ws_q   [NUM_SOURCES];
	logic [31:0] arr_q  [NUM_SOURCES];
	logic [31:0] avgm_q [NUM_SOURCES];
	logic [9:0]  occ_q  [NUM_SOURCES];
	logic [31:0] seen_q [NUM_SOURCES];

	logic [2:0]  src_q;
	logic [63:0] now_q;
	logic [31:0] avg_q;
	logic [31:0] arrw_q;
	logic [9:0]  qw_q;
	logic [31:0] pcw_q;
	logic [63:0] el_q;
	logic        hit_q;
	logic [63:0] p1_q;
	logic [63:0] p2_q;
	logic [63:0] ex_q;
	logic [31:0] erp_q;
	logic [61:0] ebk_q;
	logic [63:0] prod_q;
	logic [63:0] d_q;

	logic        out_valid_q;
	logic        pass_q;
	logic [63:0] rate_q;
	logic [9:0]  qlev_q;
	logic [31:0] pcnt_q;

	logic [IDX_W-1:0] idx;
	logic             src_ok;
	logic [63:0]      elapsed;
	logic [29:0]      w_clamp;
	logic [29:0]      w_comp;
	logic [63:0]      d_base;
	logic [63:0]      d_floor;
	logic [61:0]      p1_w;
	logic [61:0]      p2_w;
	logic [63:0]      recip_w;
	logic [61:0]      back_w;
	logic [63:0]      ex_rem;
	logic [2:0]       ex_fix;
	logic [31:0]      ex_quo;
	logic [61:0]      prod_w;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [63:0]      div_quo;
	logic             high;
	logic [9:0]       q_new;

	assign idx     = IDX_W'(src_q);
	assign src_ok  = {6'd0, src_q} < NS;
	assign elapsed = now_q - ws_q[idx];
	assign w_clamp = (weight_q > RATE_SCALE) ? RATE_SCALE : weight_q;
	assign w_comp  = RATE_SCALE - w_clamp;
	assign d_base  = hit_q ? 64'd0 : el_q;
	assign d_floor = (d_base < {32'd0, min_window_q}) ? {32'd0, min_window_q} : d_base;

	assign p1_w    = 62'(w_clamp) * 62'(avg_q);
	assign p2_w    = 62'(w_comp) * 62'(arrw_q);
	assign prod_w  = 62'(avg_q) * 62'(RATE_SCALE);

	// ewma divide by 1e9: reciprocal estimate, back product, small fix-up
	assign recip_w = 64'(ex_q[61:30]) * 64'(RECIP_SCALE);
	assign back_w  = 62'(erp_q) * 62'(RATE_SCALE);
	assign ex_rem  = ex_q - {2'd0, ebk_q};
	assign ex_fix  = 3'(ex_rem >= SCALE_X1) + 3'(ex_rem >= SCALE_X2) +
		3'(ex_rem >= SCALE_X3) + 3'(ex_rem >= SCALE_X4);
	assign ex_quo  = erp_q + {29'd0, ex_fix};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_window_q <= MIN_WINDOW_RST;
			window_q     <= WINDOW_RST;
			weight_q     <= WEIGHT_RST;
			qlimit_q     <= QLIMIT_RST;
			min_avg_q    <= MIN_AVG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_WINDOW: min_window_q <= cfg_data[31:0];
				REG_WINDOW:     window_q     <= cfg_data;
				REG_WEIGHT:     weight_q     <= cfg_data[29:0];
				REG_QLIMIT:     qlimit_q     <= cfg_data[9:0];
				REG_MIN_AVG:    min_avg_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= source;
			now_q <= timestamp_ns;
		end
		if (cmd.load) begin
			avg_q  <= floor_avg(avgm_q[idx], min_avg_q);
			arrw_q <= arr_q[idx];
			qw_q   <= occ_q[idx];
			pcw_q  <= seen_q[idx];
			el_q   <= elapsed;
			hit_q  <= elapsed >= {24'd0, window_q};
		end
		if (cmd.mul) begin
			p1_q <= {2'd0, p1_w};
			p2_q <= {2'd0, p2_w};
		end
		if (cmd.ewma_sum) begin
			ex_q <= p1_q + p2_q;
		end
		if (cmd.ewma_recip) begin
			erp_q <= recip_w[62:31];
		end
		if (cmd.ewma_back) begin
			ebk_q <= back_w;
		end
		if (cmd.ewma_take) begin
			avg_q <= floor_avg(ex_quo, min_avg_q);
		end
		if (cmd.rate_mul) begin
			prod_q <= {2'd0, prod_w};
			d_q    <= (d_floor == 64'd0) ? 64'd1 : d_floor;
		end
	end

	assign div_start = cmd.rate_start;

	rsu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign high  = div_quo >= {32'd0, avg_q};
	always_comb begin
		q_new = qw_q;
		if (high) begin
			if (qw_q != 10'd0) q_new = qw_q - 10'd1;
		end else if (qw_q < qlimit_q) begin
			q_new = qw_q + 10'd1;
		end
	end

	// per-source state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				ws_q[i]   <= '0;
				arr_q[i]  <= '0;
				avgm_q[i] <= '0;
				occ_q[i]  <= '0;
				seen_q[i] <= '0;
			end
		end else if (cmd.finish && src_ok) begin
			if (hit_q) ws_q[idx] <= now_q;
			arr_q[idx]  <= hit_q ? 32'd1 : sat_inc(arrw_q);
			avgm_q[idx] <= avg_q;
			occ_q[idx]  <= q_new;
			seen_q[idx] <= sat_inc(pcw_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (src_ok) begin
				pass_q <= (q_new < qlimit_q) | high;
				rate_q <= div_quo;
				qlev_q <= q_new;
				pcnt_q <= sat_inc(pcw_q);
			end else begin
				pass_q <= 1'b1;
				rate_q <= '0;
				qlev_q <= '0;
				pcnt_q <= '0;
			end
		end
	end

	assign sts.src_ok   = src_ok;
	assign sts.win_hit  = hit_q;
	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid    = out_valid_q;
	assign pass         = pass_q;
	assign shaped_rate  = rate_q;
	assign queue_level  = qlev_q;
	assign packet_count = pcnt_q;

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not presented after finish");

endmodule

FILE: design/rsu_ctrl.sv
// ----------------------------------------------------------------------------
// rsu_ctrl
// Sequencer: load, window-close EWMA update, in-table rate divide, finish.
// ----------------------------------------------------------------------------
module rsu_ctrl import rsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rsu_sts_t sts,
	output rsu_cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_LOAD  = 11'b00000000010,
		S_MUL   = 11'b00000000100,
		S_ESUM  = 11'b00000001000,
		S_EREC  = 11'b00000010000,
		S_EBACK = 11'b00000100000,
		S_EFIX  = 11'b00001000000,
		S_RMUL  = 11'b00010000000,
		S_RDIV  = 11'b00100000000,
		S_RWAIT = 11'b01000000000,
		S_FIN   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.src_ok ? S_MUL : S_FIN;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = sts.win_hit ? S_ESUM : S_RMUL;
			end
			S_ESUM: begin
				cmd.ewma_sum = 1'b1;
				state_d      = S_EREC;
			end
			S_EREC: begin
				cmd.ewma_recip = 1'b1;
				state_d        = S_EBACK;
			end
			S_EBACK: begin
				cmd.ewma_back = 1'b1;
				state_d       = S_EFIX;
			end
			S_EFIX: begin
				cmd.ewma_take = 1'b1;
				state_d       = S_RMUL;
			end
			S_RMUL: begin
				cmd.rate_mul = 1'b1;
				state_d      = S_RDIV;
			end
			S_RDIV: begin
				cmd.rate_start = 1'b1;
				state_d        = S_RWAIT;
			end
			S_RWAIT: begin
				if (sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
